// ===== rtl/core/hl7t_pkg.sv =====
// Shared types, constants and character classes for the HL7 line tokenizer.
`timescale 1ns / 1ps
package hl7t_pkg;

  localparam int CHAR_BITS   = 16;
  localparam int POS_W       = 16;
  localparam int CFG_IDX_W   = 3;
  localparam int ESC_MAX_DEF = 32;
  localparam int ID_LEN      = 5;
  localparam int ID_IW       = 3;

  localparam logic [POS_W-1:0] MAX_LINE = 16'd65535;

  localparam logic [CHAR_BITS-1:0] CH_A  = CHAR_BITS'(8'h41);
  localparam logic [CHAR_BITS-1:0] CH_Z  = CHAR_BITS'(8'h5A);
  localparam logic [CHAR_BITS-1:0] CH_0  = CHAR_BITS'(8'h30);
  localparam logic [CHAR_BITS-1:0] CH_9  = CHAR_BITS'(8'h39);
  localparam logic [CHAR_BITS-1:0] CH_CR = CHAR_BITS'(8'h0D);
  localparam logic [CHAR_BITS-1:0] CH_LF = CHAR_BITS'(8'h0A);
  localparam logic [CHAR_BITS-1:0] CH_M  = CHAR_BITS'(8'h4D);
  localparam logic [CHAR_BITS-1:0] CH_S  = CHAR_BITS'(8'h53);
  localparam logic [CHAR_BITS-1:0] CH_H  = CHAR_BITS'(8'h48);
  localparam logic [CHAR_BITS-1:0] CH_TAB = CHAR_BITS'(8'h09);
  localparam logic [CHAR_BITS-1:0] CH_SP  = CHAR_BITS'(8'h20);

  localparam logic [2:0] KIND_SEG   = 3'd0;
  localparam logic [2:0] KIND_FIELD = 3'd1;
  localparam logic [2:0] KIND_COMP  = 3'd2;
  localparam logic [2:0] KIND_REP   = 3'd3;
  localparam logic [2:0] KIND_SUB   = 3'd4;
  localparam logic [2:0] KIND_ESC   = 3'd5;
  localparam logic [2:0] KIND_VALUE = 3'd6;

  localparam logic [CFG_IDX_W-1:0] REG_FIELD_SEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMP_SEP  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_REP_SEP   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ESC_CHAR  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SUB_SEP   = 3'd4;

  typedef enum logic [1:0] {M_WS, M_ID, M_MAIN, M_ESC} lex_mode_t;

  typedef enum logic [3:0] {
    B_IDLE, B_HEAD, B_IDDEC, B_RES, B_RPLID, B_FEED, B_UNC,
    B_RPLESC, B_EOL, B_FIN, B_CLOSE, B_FLUSH
  } back_state_t;

  typedef struct packed {
    logic [CHAR_BITS-1:0] char_code;
    logic                 eol;
    logic                 space;
    logic                 upper;
  } q_item_t;

  typedef struct packed {
    logic [POS_W-1:0] start;
    logic [POS_W-1:0] length;
    logic [2:0]       kind;
  } token_t;

  typedef struct packed {
    logic       known;
    logic [2:0] width;
  } id_dec_t;

  typedef logic [ID_LEN-1:0][CHAR_BITS-1:0] id_buf_t;

  function automatic logic is_space(input logic [CHAR_BITS-1:0] c);
    return (c == CH_SP) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_upper(input logic [CHAR_BITS-1:0] c);
    return (c >= CH_A) && (c <= CH_Z);
  endfunction

  function automatic logic is_alnum(input logic [CHAR_BITS-1:0] c);
    return is_upper(c) || ((c >= CH_0) && (c <= CH_9));
  endfunction

  // Segment ID decision over the first characters of the line
  function automatic id_dec_t id_decide(input id_buf_t b, input logic [2:0] n,
                                        input logic eol, input logic [CHAR_BITS-1:0] fs);
    id_dec_t d;
    d.known = 1'b1;
    d.width = 3'd0;
    if (n >= 3'd1 && !is_upper(b[0])) begin
      d.width = 3'd0;
    end else if (n >= 3'd2 && !is_alnum(b[1])) begin
      d.width = 3'd0;
    end else if (n < 3'd3) begin
      d.known = eol;
    end else if (!is_alnum(b[2])) begin
      d.width = 3'd0;
    end else if (b[0] == CH_M && b[1] == CH_S && b[2] == CH_H) begin
      d.width = 3'd3;
    end else if (n == 3'd3) begin
      d.known = eol;
      d.width = 3'd3;
    end else if (!(b[0] == CH_Z && is_alnum(b[3]))) begin
      d.width = (b[3] == fs) ? 3'd3 : 3'd0;
    end else if (n == 3'd4) begin
      d.known = eol;
      d.width = 3'd4;
    end else if (b[4] == fs) begin
      d.width = 3'd4;
    end else begin
      d.width = (b[3] == fs) ? 3'd3 : 3'd0;
    end
    return d;
  endfunction

endpackage

// ===== rtl/core/hl7t_front.sv =====
// Input stage: takes characters, classifies them and queues them for the back end.
`timescale 1ns / 1ps
module hl7t_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hl7t_pkg::CHAR_BITS-1:0] char_code,
  input  logic                           end_of_line,
  output hl7t_pkg::q_item_t              q_item,
  output logic                           q_valid,
  input  logic                           q_ready
);
  import hl7t_pkg::*;

  q_item_t    entry [2];
  logic       wp;
  logic       rp;
  logic [1:0] cnt;
  logic       push;
  logic       pop;
  q_item_t    incoming;

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_item   = entry[rp];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    incoming.char_code = char_code;
    incoming.eol       = end_of_line;
    incoming.space     = is_space(char_code);
    incoming.upper     = is_upper(char_code);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wp] <= incoming;
    end
    if (rst) begin
      wp  <= 1'b0;
      rp  <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== rtl/core/hl7t_back.sv =====
// Tokenizing sequencer: segment ID check, delimiters, escapes, replay and output stage.
`timescale 1ns / 1ps
module hl7t_back #(
  parameter int ESC_MAX = hl7t_pkg::ESC_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [hl7t_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hl7t_pkg::CHAR_BITS-1:0] cfg_data,
  input  hl7t_pkg::q_item_t              q_item,
  input  logic                           q_valid,
  output logic                           q_ready,
  output hl7t_pkg::token_t               out_tok,
  output logic                           out_last,
  output logic                           out_valid,
  input  logic                           out_ready
);
  import hl7t_pkg::*;

  localparam int CW = $clog2(ESC_MAX + 1);
  localparam int IW = $clog2(ESC_MAX);

  logic [CHAR_BITS-1:0] fs, cs, rs, es, ss;

  back_state_t state, state_next;
  lex_mode_t   mode, mode_next;
  logic [POS_W-1:0] pos, pos_next;
  logic [POS_W-1:0] run_start, run_start_next;
  logic             run_open, run_open_next;
  logic [POS_W-1:0] pend, pend_next;
  logic [CW-1:0]    esc_cnt, esc_cnt_next;
  id_buf_t          idb, idb_next;
  logic [2:0]       idn, idn_next;
  logic [CW-1:0]    ri, ri_next;
  logic [CW-1:0]    rn, rn_next;
  logic [ID_IW-1:0] idr, idr_next;
  logic [POS_W-1:0] id_base, id_base_next;
  logic [POS_W-1:0] esc_base, esc_base_next;
  logic [2:0]       res_w, res_w_next;
  logic             in_fin, in_fin_next;
  logic [CHAR_BITS-1:0] cur_c, cur_c_next;
  logic [POS_W-1:0] cur_p, cur_p_next;
  logic             cur_eol, cur_eol_next;
  logic             cur_space, cur_space_next;
  logic             cur_upper, cur_upper_next;

  token_t hold, hold_next;
  logic   hold_valid, hold_valid_next;
  token_t out_tok_next;
  logic   out_last_next;
  logic   out_valid_next;

  logic [CHAR_BITS-1:0] esc_mem [ESC_MAX];
  logic [CHAR_BITS-1:0] rdata;
  logic                 mem_we;
  logic [IW-1:0]        mem_raddr;

  // feed unit
  logic [CHAR_BITS-1:0] fc;
  logic [POS_W-1:0]     fp;
  logic      f_emit, f_cons, f_unc, f_we;
  token_t    f_tok;
  lex_mode_t f_mode;
  logic      f_run_open;
  logic [POS_W-1:0] f_run_start, f_pend;
  logic [CW-1:0]    f_esc_cnt;
  logic       d_hit;
  logic [2:0] d_kind;

  logic    emit_req, emit_ok, slot;
  token_t  emit_tok;
  logic    flush_push;
  id_dec_t dec;

  assign slot    = !out_valid || out_ready;
  assign emit_ok = !hold_valid || slot;

  always_comb begin
    fc = cur_c;
    fp = cur_p;
    case (state)
      B_RPLID: begin
        fc = idb[idr];
        fp = id_base + POS_W'(idr);
      end
      B_RPLESC: begin
        fc = rdata;
        fp = esc_base + POS_W'(ri);
      end
      default: ;
    endcase

    f_emit      = 1'b0;
    f_cons      = 1'b0;
    f_unc       = 1'b0;
    f_we        = 1'b0;
    f_tok.start  = fp;
    f_tok.length = POS_W'(1);
    f_tok.kind   = KIND_VALUE;
    f_mode      = mode;
    f_run_open  = run_open;
    f_run_start = run_start;
    f_pend      = pend;
    f_esc_cnt   = esc_cnt;

    d_hit  = 1'b1;
    d_kind = KIND_FIELD;
    if (fc == fs) begin
      d_kind = KIND_FIELD;
    end else if (fc == cs) begin
      d_kind = KIND_COMP;
    end else if (fc == rs) begin
      d_kind = KIND_REP;
    end else if (fc == ss) begin
      d_kind = KIND_SUB;
    end else begin
      d_hit = 1'b0;
    end

    if (mode == M_ESC) begin
      if (fc == fs || fc == CH_CR || fc == CH_LF) begin
        f_unc = 1'b1;
      end else if (fc == es) begin
        f_emit       = 1'b1;
        f_tok.start  = pend;
        f_tok.length = fp - pend + POS_W'(1);
        f_tok.kind   = KIND_ESC;
        f_mode       = M_MAIN;
        f_esc_cnt    = '0;
        f_cons       = 1'b1;
      end else if (esc_cnt >= CW'(ESC_MAX)) begin
        f_unc = 1'b1;
      end else begin
        f_we      = 1'b1;
        f_esc_cnt = esc_cnt + 1'b1;
        f_cons    = 1'b1;
      end
    end else if (run_open && (d_hit || fc == es || fc == CH_CR || fc == CH_LF)) begin
      // close the open run first; a delimiter is not consumed here and emits its own token when it is fed again
      f_emit       = 1'b1;
      f_tok.start  = run_start;
      f_tok.length = fp - run_start;
      f_tok.kind   = KIND_VALUE;
      f_run_open   = 1'b0;
      f_cons       = !d_hit;
      if (!d_hit && fc == es) begin
        f_mode    = M_ESC;
        f_pend    = fp;
        f_esc_cnt = '0;
      end
    end else if (d_hit) begin
      f_emit      = 1'b1;
      f_tok.start = fp;
      f_tok.kind  = d_kind;
      f_cons      = 1'b1;
    end else if (fc == es) begin
      f_mode    = M_ESC;
      f_pend    = fp;
      f_esc_cnt = '0;
      f_cons    = 1'b1;
    end else if (fc == CH_CR || fc == CH_LF) begin
      f_cons = 1'b1;
    end else begin
      if (!run_open) begin
        f_run_open  = 1'b1;
        f_run_start = fp;
      end
      f_cons = 1'b1;
    end
  end

  always_comb begin
    state_next     = state;
    mode_next      = mode;
    pos_next       = pos;
    run_start_next = run_start;
    run_open_next  = run_open;
    pend_next      = pend;
    esc_cnt_next   = esc_cnt;
    idb_next       = idb;
    idn_next       = idn;
    ri_next        = ri;
    rn_next        = rn;
    idr_next       = idr;
    id_base_next   = id_base;
    esc_base_next  = esc_base;
    res_w_next     = res_w;
    in_fin_next    = in_fin;
    cur_c_next     = cur_c;
    cur_p_next     = cur_p;
    cur_eol_next   = cur_eol;
    cur_space_next = cur_space;
    cur_upper_next = cur_upper;
    q_ready        = 1'b0;
    emit_req       = 1'b0;
    emit_tok       = f_tok;
    flush_push     = 1'b0;
    mem_we         = 1'b0;
    dec            = id_decide(idb, idn, 1'b0, fs);

    case (state)
      B_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          cur_c_next     = q_item.char_code;
          cur_eol_next   = q_item.eol;
          cur_space_next = q_item.space;
          cur_upper_next = q_item.upper;
          in_fin_next    = 1'b0;
          state_next     = B_HEAD;
        end
      end
      B_HEAD: begin
        state_next = B_EOL;
        if (pos < MAX_LINE) begin
          pos_next   = pos + POS_W'(1);
          cur_p_next = pos;
          case (mode)
            M_WS: begin
              if (!cur_space) begin
                mode_next   = M_ID;
                pend_next   = pos;
                idb_next[0] = cur_c;
                idn_next    = 3'd1;
                if (!cur_upper) begin
                  res_w_next = 3'd0;
                  state_next = B_RES;
                end
              end
            end
            M_ID: begin
              idb_next[idn] = cur_c;
              idn_next      = idn + 3'd1;
              state_next    = B_IDDEC;
            end
            default: state_next = B_FEED;
          endcase
        end
      end
      B_IDDEC: begin
        if (dec.known) begin
          res_w_next = dec.width;
          state_next = B_RES;
        end else begin
          state_next = B_EOL;
        end
      end
      B_RES: begin
        emit_req        = (res_w != 3'd0);
        emit_tok.start  = pend;
        emit_tok.length = POS_W'(res_w);
        emit_tok.kind   = KIND_SEG;
        if (!(emit_req && !emit_ok)) begin
          mode_next    = M_MAIN;
          idr_next     = res_w;
          id_base_next = pend;
          esc_cnt_next = '0;
          state_next   = B_RPLID;
        end
      end
      B_RPLID: begin
        if (idn > idr) begin
          emit_req = f_emit;
          if (!(f_emit && !emit_ok)) begin
            mode_next      = f_mode;
            run_open_next  = f_run_open;
            run_start_next = f_run_start;
            pend_next      = f_pend;
            esc_cnt_next   = f_esc_cnt;
            mem_we         = f_we;
            if (f_unc) begin
              // escape opened inside the ID characters runs into a field separator, CR or LF, or fills the escape store
              state_next = B_UNC;
            end else if (f_cons) begin
              idr_next = idr + ID_IW'(1);
            end
          end
        end else begin
          idn_next   = 3'd0;
          state_next = in_fin ? B_FIN : B_EOL;
        end
      end
      B_FEED: begin
        emit_req = f_emit;
        if (!(f_emit && !emit_ok)) begin
          mode_next      = f_mode;
          run_open_next  = f_run_open;
          run_start_next = f_run_start;
          pend_next      = f_pend;
          esc_cnt_next   = f_esc_cnt;
          mem_we         = f_we;
          if (f_unc) begin
            state_next = B_UNC;
          end else if (f_cons) begin
            state_next = B_EOL;
          end
        end
      end
      B_UNC: begin
        // unclosed escape: the escape character stands as a value, then replay
        emit_req        = 1'b1;
        emit_tok.start  = pend;
        emit_tok.length = POS_W'(1);
        emit_tok.kind   = KIND_VALUE;
        if (emit_ok) begin
          mode_next     = M_MAIN;
          rn_next       = esc_cnt;
          esc_cnt_next  = '0;
          ri_next       = '0;
          esc_base_next = pend + POS_W'(1);
          state_next    = B_RPLESC;
        end
      end
      B_RPLESC: begin
        if (ri < rn) begin
          emit_req = f_emit;
          if (!(f_emit && !emit_ok)) begin
            mode_next      = f_mode;
            run_open_next  = f_run_open;
            run_start_next = f_run_start;
            pend_next      = f_pend;
            esc_cnt_next   = f_esc_cnt;
            mem_we         = f_we;
            if (f_cons) begin
              ri_next = ri + 1'b1;
            end
          end
        end else if (idn != 3'd0) begin
          // resume the segment ID replay at the character that stopped the escape
          state_next = B_RPLID;
        end else begin
          state_next = in_fin ? B_FIN : B_FEED;
        end
      end
      B_EOL: begin
        state_next = cur_eol ? B_FIN : B_FLUSH;
      end
      B_FIN: begin
        in_fin_next = 1'b1;
        case (mode)
          M_ID: begin
            dec        = id_decide(idb, idn, 1'b1, fs);
            res_w_next = dec.width;
            state_next = B_RES;
          end
          M_ESC:   state_next = B_UNC;
          default: state_next = B_CLOSE;
        endcase
      end
      B_CLOSE: begin
        emit_req        = run_open;
        emit_tok.start  = run_start;
        emit_tok.length = pos - run_start;
        emit_tok.kind   = KIND_VALUE;
        if (!(emit_req && !emit_ok)) begin
          mode_next      = M_WS;
          pos_next       = '0;
          run_open_next  = 1'b0;
          run_start_next = '0;
          pend_next      = '0;
          esc_cnt_next   = '0;
          idn_next       = 3'd0;
          state_next     = B_FLUSH;
        end
      end
      B_FLUSH: begin
        if (!hold_valid) begin
          state_next = B_IDLE;
        end else if (slot) begin
          flush_push = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Hold the newest token back one step so the last of an item can be marked
  always_comb begin
    hold_next       = hold;
    hold_valid_next = hold_valid;
    out_tok_next    = out_tok;
    out_last_next   = out_last;
    out_valid_next  = out_valid && !out_ready;
    if (emit_req && emit_ok) begin
      if (hold_valid) begin
        out_tok_next   = hold;
        out_last_next  = 1'b0;
        out_valid_next = 1'b1;
      end
      hold_next       = emit_tok;
      hold_valid_next = 1'b1;
    end else if (flush_push) begin
      out_tok_next    = hold;
      out_last_next   = 1'b1;
      out_valid_next  = 1'b1;
      hold_valid_next = 1'b0;
    end
  end

  assign mem_raddr = ri_next[IW-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      esc_mem[esc_cnt[IW-1:0]] <= fc;
    end
    rdata <= esc_mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    run_start <= run_start_next;
    pend      <= pend_next;
    idb       <= idb_next;
    ri        <= ri_next;
    rn        <= rn_next;
    idr       <= idr_next;
    id_base   <= id_base_next;
    esc_base  <= esc_base_next;
    res_w     <= res_w_next;
    in_fin    <= in_fin_next;
    cur_c     <= cur_c_next;
    cur_p     <= cur_p_next;
    cur_eol   <= cur_eol_next;
    cur_space <= cur_space_next;
    cur_upper <= cur_upper_next;
    hold      <= hold_next;
    out_tok   <= out_tok_next;
    out_last  <= out_last_next;
    if (rst) begin
      state      <= B_IDLE;
      mode       <= M_WS;
      pos        <= '0;
      run_open   <= 1'b0;
      esc_cnt    <= '0;
      idn        <= 3'd0;
      hold_valid <= 1'b0;
      out_valid  <= 1'b0;
      fs <= CHAR_BITS'(124);
      cs <= CHAR_BITS'(94);
      rs <= CHAR_BITS'(126);
      es <= CHAR_BITS'(92);
      ss <= CHAR_BITS'(38);
    end else begin
      state      <= state_next;
      mode       <= mode_next;
      pos        <= pos_next;
      run_open   <= run_open_next;
      esc_cnt    <= esc_cnt_next;
      idn        <= idn_next;
      hold_valid <= hold_valid_next;
      out_valid  <= out_valid_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_FIELD_SEP: fs <= cfg_data;
          REG_COMP_SEP:  cs <= cfg_data;
          REG_REP_SEP:   rs <= cfg_data;
          REG_ESC_CHAR:  es <= cfg_data;
          REG_SUB_SEP:   ss <= cfg_data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== rtl/core/hl7_line_tokenizer.sv =====
// Top level of the HL7 v2 line tokenizer.
// Usage:
//   Characters of one line arrive on in_valid/in_ready with char_code and
//   end_of_line (set on the last character). Tokens leave on out_valid/
//   out_ready as token_start, token_length, token_kind and last_of_run, which
//   flags the final token caused by a request.
//   Delimiters are written through cfg_we/cfg_index/cfg_data while no line
//   is in progress; index 0 field, 1 component, 2 repetition, 3 escape,
//   4 subcomponent.
//   A two-entry input queue takes characters while the sequencer works. The
//   sequencer works on one character at a time and takes extra steps when a
//   delimiter also closes a value run, at the end of a line, and for each
//   character replayed after a segment ID check or an unclosed escape. Its
//   single state machine and the one read port of the escape store set its
//   pace. A token leaves once the next token of its request is produced, or
//   at the end of the request when it is the last.
//   Reset restores the default delimiters and starts a new line. When the
//   receiver stalls, one token waits in the output register and one more is
//   held behind it; then the sequencer and later the input queue stop.
`timescale 1ns / 1ps
module hl7_line_tokenizer #(
  parameter int ESC_MAX = hl7t_pkg::ESC_MAX_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic [hl7t_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [hl7t_pkg::CHAR_BITS-1:0] cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [hl7t_pkg::CHAR_BITS-1:0] char_code,
  input  logic                           end_of_line,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [hl7t_pkg::POS_W-1:0]     token_start,
  output logic [hl7t_pkg::POS_W-1:0]     token_length,
  output logic [2:0]                     token_kind,
  output logic                           last_of_run
);
  import hl7t_pkg::*;

  q_item_t q_item;
  logic    q_valid;
  logic    q_ready;
  token_t  out_tok;

  hl7t_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .char_code  (char_code),
    .end_of_line(end_of_line),
    .q_item     (q_item),
    .q_valid    (q_valid),
    .q_ready    (q_ready)
  );

  hl7t_back #(
    .ESC_MAX(ESC_MAX)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_item   (q_item),
    .q_valid  (q_valid),
    .q_ready  (q_ready),
    .out_tok  (out_tok),
    .out_last (last_of_run),
    .out_valid(out_valid),
    .out_ready(out_ready)
  );

  assign token_start  = out_tok.start;
  assign token_length = out_tok.length;
  assign token_kind   = out_tok.kind;

  a_len_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (token_length != '0))
    else $error("token with zero length");

  a_queue_fill: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> q_valid)
    else $error("accepted request missing from queue");

  a_full_queue: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> q_valid)
    else $error("input blocked with empty queue");

endmodule
